/* design/stpt_pkg.sv */
// Package for the segment table page translator.
// Holds the shared widths, reset values, codes and enumerated types.
// Depends on nothing; every other file of the block but stpt_ram refers to it.
package stpt_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int ADDR_BITS_DEF    = 52;

   localparam int OPCODE_W       = 2;
   localparam int STATUS_W       = 3;
   localparam int KIND_W         = 2;
   localparam int NODE_W         = 9;
   localparam int SEG_NODE_W     = 8;
   localparam int PAGE_INDEX_W   = 40;
   localparam int PAGE_ORDER_W   = 5;
   localparam int BLOCK_SHIFT_W  = 6;
   localparam int MAX_NODES_W    = 9;
   localparam int REG_IDX_W      = 2;
   localparam int CSR_ADDR_W     = REG_IDX_W + 2;
   localparam int CSR_DATA_W     = 32;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [PAGE_ORDER_W-1:0]  PAGE_ORDER_RESET  = 5'd12;
   localparam logic [BLOCK_SHIFT_W-1:0] BLOCK_SHIFT_RESET = 6'd27;
   localparam logic [MAX_NODES_W-1:0]   MAX_NODES_RESET   = 9'd16;

   typedef enum logic [OPCODE_W-1:0] {
      OP_CLEAR     = 2'd0,
      OP_ADD       = 2'd1,
      OP_TRANSLATE = 2'd2,
      OP_NOP       = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 3'd0,
      STATUS_OUT_OF_RANGE = 3'd1,
      STATUS_NO_NODE      = 3'd2,
      STATUS_TABLE_FULL   = 3'd3,
      STATUS_SKIPPED      = 3'd4
   } status_type;

   // Classified request kinds passed from the front end to the back end.
   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ADD   = 2'd2,
      KIND_WALK  = 2'd3
   } kind_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_PAGE_ORDER  = 2'd0,
      REG_BLOCK_SHIFT = 2'd1,
      REG_MAX_NODES   = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      BACK_IDLE = 2'd0,
      BACK_WALK = 2'd1,
      BACK_ADDR = 2'd2
   } back_state_type;

endpackage

/* design/stpt_req_if.sv */
// Request channel of the segment table page translator.
// Carries valid, ready and the request payload; widths come from stpt_pkg.
interface stpt_req_if #(
   parameter int ADDR_BITS = stpt_pkg::ADDR_BITS_DEF
) ();
   logic                                  valid;
   logic                                  ready;
   logic [stpt_pkg::OPCODE_W-1:0]         opcode;
   logic [ADDR_BITS-1:0]                  block_start;
   logic [ADDR_BITS-1:0]                  range_end;
   logic                                  block_online;
   logic signed [stpt_pkg::NODE_W-1:0]    node;
   logic [stpt_pkg::PAGE_INDEX_W-1:0]     page_index;

   modport source (
      output valid, opcode, block_start, range_end, block_online, node, page_index,
      input  ready
   );
   modport sink (
      input  valid, opcode, block_start, range_end, block_online, node, page_index,
      output ready
   );
endinterface

/* design/stpt_rsp_if.sv */
// Result channel of the segment table page translator.
// Carries valid, ready and the result payload; widths come from stpt_pkg.
interface stpt_rsp_if #(
   parameter int ADDR_BITS    = stpt_pkg::ADDR_BITS_DEF,
   parameter int MAX_SEGMENTS = stpt_pkg::MAX_SEGMENTS_DEF
) ();
   localparam int COUNT_W = $clog2(MAX_SEGMENTS + 1);

   logic                          valid;
   logic                          ready;
   logic [stpt_pkg::STATUS_W-1:0] status;
   logic [ADDR_BITS-1:0]          phys_addr;
   logic [COUNT_W-1:0]            segment_count;

   modport source (output valid, status, phys_addr, segment_count, input ready);
   modport sink (input valid, status, phys_addr, segment_count, output ready);
endinterface

/* design/segment_table_page_translator.sv */
// Top level of the segment table page translator: configuration registers,
// front end, request queue and back end. Uses stpt_pkg and both channel interfaces.
//
//   Channel   Direction  Handshake                Carries
//   req       in         valid / ready            opcode, block, range, node, page index
//   rsp       out        valid / ready            status, physical address, segment count
//   csr       in         psel, penable, pready    page_order, block_shift, max_nodes
//
// Clear, add and any request settled by the front end are answered from the idle state.
// A translate walks the table: the walk reads one table entry per cycle through the single
// read port of the segment memory.
// Synchronous reset empties the table and the queue and restores the register defaults.
// Requests queue up while a result waits or a walk runs; a full queue drops req.ready.
module segment_table_page_translator #(
   parameter int MAX_SEGMENTS = stpt_pkg::MAX_SEGMENTS_DEF,
   parameter int ADDR_BITS    = stpt_pkg::ADDR_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   stpt_req_if.sink                          req,
   stpt_rsp_if.source                        rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [stpt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [stpt_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [stpt_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   localparam int CMD_W = stpt_pkg::KIND_W + stpt_pkg::STATUS_W + stpt_pkg::SEG_NODE_W
                          + 3 * ADDR_BITS;

   logic [stpt_pkg::PAGE_ORDER_W-1:0]  page_order_ff, page_order_in;
   logic [stpt_pkg::BLOCK_SHIFT_W-1:0] block_shift_ff, block_shift_in;
   logic [stpt_pkg::MAX_NODES_W-1:0]   max_nodes_ff, max_nodes_in;
   stpt_pkg::reg_index_type            reg_idx;
   logic                               csr_write;

   logic                               push;
   logic                               pop;
   logic                               queue_full;
   logic                               queue_empty;
   logic [CMD_W-1:0]                   push_data;
   logic [CMD_W-1:0]                   pop_data;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_idx   = stpt_pkg::reg_index_type'(paddr[stpt_pkg::CSR_ADDR_W-1:2]);

   always_comb begin
      page_order_in  = page_order_ff;
      block_shift_in = block_shift_ff;
      max_nodes_in   = max_nodes_ff;
      prdata         = '0;
      case (reg_idx)
         stpt_pkg::REG_PAGE_ORDER: begin
            prdata = stpt_pkg::CSR_DATA_W'(page_order_ff);
            if (csr_write) begin
               page_order_in = pwdata[stpt_pkg::PAGE_ORDER_W-1:0];
            end
         end
         stpt_pkg::REG_BLOCK_SHIFT: begin
            prdata = stpt_pkg::CSR_DATA_W'(block_shift_ff);
            if (csr_write) begin
               block_shift_in = pwdata[stpt_pkg::BLOCK_SHIFT_W-1:0];
            end
         end
         stpt_pkg::REG_MAX_NODES: begin
            prdata = stpt_pkg::CSR_DATA_W'(max_nodes_ff);
            if (csr_write) begin
               max_nodes_in = pwdata[stpt_pkg::MAX_NODES_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_order_ff  <= stpt_pkg::PAGE_ORDER_RESET;
         block_shift_ff <= stpt_pkg::BLOCK_SHIFT_RESET;
         max_nodes_ff   <= stpt_pkg::MAX_NODES_RESET;
      end else begin
         page_order_ff  <= page_order_in;
         block_shift_ff <= block_shift_in;
         max_nodes_ff   <= max_nodes_in;
      end
   end

   stpt_front #(
      .ADDR_BITS (ADDR_BITS)
   ) u_stpt_front (
      .req         (req),
      .page_order  (page_order_ff),
      .block_shift (block_shift_ff),
      .max_nodes   (max_nodes_ff),
      .queue_full  (queue_full),
      .push        (push),
      .cmd_data    (push_data)
   );

   stpt_queue #(
      .WIDTH (CMD_W)
   ) u_stpt_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .pop_data  (pop_data)
   );

   stpt_back #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .ADDR_BITS    (ADDR_BITS)
   ) u_stpt_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!queue_empty),
      .cmd_data  (pop_data),
      .pop       (pop),
      .rsp       (rsp)
   );
endmodule

/* design/stpt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the segment table; no dependencies.
module stpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

/* design/stpt_queue.sv */
// Short request queue between the front end and the back end.
// Depth comes from stpt_pkg; the entry width is a parameter.
module stpt_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);
   localparam int DEPTH = stpt_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

/* design/stpt_front.sv */
// Front end: accepts requests and classifies them for the back end.
// Clips added blocks, checks nodes and offsets; uses stpt_pkg and stpt_req_if.
module stpt_front #(
   parameter int ADDR_BITS = stpt_pkg::ADDR_BITS_DEF
) (
   stpt_req_if.sink                            req,
   input  logic [stpt_pkg::PAGE_ORDER_W-1:0]   page_order,
   input  logic [stpt_pkg::BLOCK_SHIFT_W-1:0]  block_shift,
   input  logic [stpt_pkg::MAX_NODES_W-1:0]    max_nodes,
   input  logic                                queue_full,
   output logic                                push,
   output logic [stpt_pkg::KIND_W + stpt_pkg::STATUS_W + stpt_pkg::SEG_NODE_W
                 + 3 * ADDR_BITS - 1:0]        cmd_data
);
   localparam int SHIFTED_W = stpt_pkg::PAGE_INDEX_W + (1 << stpt_pkg::PAGE_ORDER_W) - 1;

   typedef struct packed {
      stpt_pkg::kind_type                kind;
      stpt_pkg::status_type              status;
      logic [ADDR_BITS-1:0]              start;
      logic [ADDR_BITS-1:0]              limit;
      logic [stpt_pkg::SEG_NODE_W-1:0]   node;
      logic [ADDR_BITS-1:0]              offset;
   } cmd_type;

   cmd_type                cmd;
   logic [ADDR_BITS-1:0]   span;
   logic [ADDR_BITS-1:0]   sum;
   logic                   carry;
   logic [ADDR_BITS-1:0]   limit;
   logic [SHIFTED_W-1:0]   shifted;
   logic                   overflow;
   logic                   skip_early;
   logic                   no_node;
   logic                   node_high;

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;
   assign cmd_data  = cmd;

   // A block covers 2^block_shift bytes; larger shifts saturate to the whole space.
   assign span         = ~({ADDR_BITS{1'b1}} << block_shift);
   assign {carry, sum} = {1'b0, req.block_start} + {1'b0, span};
   assign limit        = (carry || (sum > req.range_end)) ? req.range_end : sum;

   assign shifted  = SHIFTED_W'(req.page_index) << page_order;
   assign overflow = |(shifted >> ADDR_BITS);

   assign skip_early = (req.block_start >= req.range_end) || !req.block_online;
   assign no_node    = req.node[stpt_pkg::NODE_W-1];
   assign node_high  = $unsigned(req.node) >= max_nodes;

   always_comb begin
      cmd.kind   = stpt_pkg::KIND_DONE;
      cmd.status = stpt_pkg::STATUS_OK;
      cmd.start  = req.block_start;
      cmd.limit  = limit;
      cmd.node   = req.node[stpt_pkg::SEG_NODE_W-1:0];
      cmd.offset = shifted[ADDR_BITS-1:0];
      unique case (stpt_pkg::opcode_type'(req.opcode))
         stpt_pkg::OP_CLEAR: begin
            cmd.kind = stpt_pkg::KIND_CLEAR;
         end
         stpt_pkg::OP_ADD: begin
            priority if (skip_early) begin
               cmd.status = stpt_pkg::STATUS_SKIPPED;
            end else if (no_node) begin
               cmd.status = stpt_pkg::STATUS_NO_NODE;
            end else if (node_high) begin
               cmd.status = stpt_pkg::STATUS_SKIPPED;
            end else begin
               cmd.kind = stpt_pkg::KIND_ADD;
            end
         end
         stpt_pkg::OP_TRANSLATE: begin
            if (no_node || overflow) begin
               cmd.status = stpt_pkg::STATUS_OUT_OF_RANGE;
            end else begin
               cmd.kind = stpt_pkg::KIND_WALK;
            end
         end
         stpt_pkg::OP_NOP: begin
            cmd.kind = stpt_pkg::KIND_DONE;
         end
      endcase
   end
endmodule

/* design/stpt_back.sv */
// Back end: owns the segment table and the result register.
// Appends and merges segments and walks the table; uses stpt_pkg, stpt_ram, stpt_rsp_if.
module stpt_back #(
   parameter int MAX_SEGMENTS = stpt_pkg::MAX_SEGMENTS_DEF,
   parameter int ADDR_BITS    = stpt_pkg::ADDR_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  logic [stpt_pkg::KIND_W + stpt_pkg::STATUS_W + stpt_pkg::SEG_NODE_W
                 + 3 * ADDR_BITS - 1:0] cmd_data,
   output logic                         pop,
   stpt_rsp_if.source                   rsp
);
   localparam int IDX_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int COUNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam int ENTRY_W = 2 * ADDR_BITS + stpt_pkg::SEG_NODE_W;
   localparam int SIZE_W  = ADDR_BITS + 1;
   localparam int REM_W   = ADDR_BITS + 2;

   typedef struct packed {
      stpt_pkg::kind_type                kind;
      stpt_pkg::status_type              status;
      logic [ADDR_BITS-1:0]              start;
      logic [ADDR_BITS-1:0]              limit;
      logic [stpt_pkg::SEG_NODE_W-1:0]   node;
      logic [ADDR_BITS-1:0]              offset;
   } cmd_type;

   cmd_type                          cmd;
   stpt_pkg::back_state_type         state_ff, state_in;

   logic [COUNT_W-1:0]               used_ff, used_in;
   logic [ADDR_BITS-1:0]             last_start_ff, last_start_in;
   logic [ADDR_BITS-1:0]             last_end_ff, last_end_in;
   logic [stpt_pkg::SEG_NODE_W-1:0]  last_node_ff, last_node_in;

   logic [COUNT_W-1:0]               idx_ff, idx_in;
   logic                             p1_ff, p1_in;
   logic                             a_valid_ff, a_valid_in;
   logic                             a_match_ff, a_match_in;
   logic [SIZE_W-1:0]                a_size_ff, a_size_in;
   logic [ADDR_BITS-1:0]             a_start_ff, a_start_in;
   logic [ADDR_BITS-1:0]             off_ff, off_in;
   logic [stpt_pkg::SEG_NODE_W-1:0]  target_ff, target_in;
   logic [ADDR_BITS-1:0]             hit_start_ff, hit_start_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   stpt_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [ADDR_BITS-1:0]             rsp_addr_ff, rsp_addr_in;
   logic [COUNT_W-1:0]               rsp_count_ff, rsp_count_in;

   logic                             wr_en;
   logic [IDX_W-1:0]                 wr_addr;
   logic [ENTRY_W-1:0]               wr_data;
   logic [ENTRY_W-1:0]               rd_data;
   logic [ADDR_BITS-1:0]             rd_start;
   logic [ADDR_BITS-1:0]             rd_limit;
   logic [stpt_pkg::SEG_NODE_W-1:0]  rd_node;

   logic                             out_free;
   logic [COUNT_W-1:0]               last_idx;
   logic                             merge;
   logic                             table_full;
   logic                             issue;
   logic [SIZE_W-1:0]                size_next;
   logic [REM_W-1:0]                 rem;
   logic                             live;
   logic                             hit;
   logic                             walk_done;

   stpt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_SEGMENTS)
   ) u_stpt_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign cmd                           = cmd_type'(cmd_data);
   assign {rd_start, rd_limit, rd_node} = rd_data;

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign last_idx   = used_ff - COUNT_W'(1);
   // A segment ending at the top of the address space never merges.
   assign merge      = (used_ff != '0) && (last_end_ff != '1)
                       && (cmd.start == last_end_ff + ADDR_BITS'(1))
                       && (last_node_ff == cmd.node);
   assign table_full = (used_ff >= COUNT_W'(MAX_SEGMENTS));

   assign issue      = (state_ff == stpt_pkg::BACK_WALK) && (idx_ff < used_ff);
   assign size_next  = {1'b0, rd_limit - rd_start} + SIZE_W'(1);
   assign rem        = {2'b00, off_ff} - {1'b0, a_size_ff};
   assign live       = (state_ff == stpt_pkg::BACK_WALK) && a_valid_ff && a_match_ff;
   assign hit        = live && rem[REM_W-1];
   assign walk_done  = (state_ff == stpt_pkg::BACK_WALK) && !issue && !p1_ff && !a_valid_ff;

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.phys_addr     = rsp_addr_ff;
   assign rsp.segment_count = rsp_count_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stpt_pkg::BACK_IDLE: begin
            if (cmd_valid && out_free && (cmd.kind == stpt_pkg::KIND_WALK)) begin
               state_in = stpt_pkg::BACK_WALK;
            end
         end
         stpt_pkg::BACK_WALK: begin
            if (hit) begin
               state_in = stpt_pkg::BACK_ADDR;
            end else if (walk_done) begin
               state_in = stpt_pkg::BACK_IDLE;
            end
         end
         stpt_pkg::BACK_ADDR: begin
            state_in = stpt_pkg::BACK_IDLE;
         end
         default: begin
            state_in = stpt_pkg::BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = used_ff[IDX_W-1:0];
      wr_data       = {cmd.start, cmd.limit, cmd.node};
      used_in       = used_ff;
      last_start_in = last_start_ff;
      last_end_in   = last_end_ff;
      last_node_in  = last_node_ff;
      idx_in        = issue ? idx_ff + COUNT_W'(1) : idx_ff;
      p1_in         = issue;
      a_valid_in    = p1_ff && (state_ff == stpt_pkg::BACK_WALK);
      a_match_in    = (rd_node == target_ff);
      a_size_in     = size_next;
      a_start_in    = rd_start;
      off_in        = off_ff;
      target_in     = target_ff;
      hit_start_in  = hit_start_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_count_in  = rsp_count_ff;
      unique case (state_ff)
         stpt_pkg::BACK_IDLE: begin
            if (cmd_valid && out_free) begin
               pop           = 1'b1;
               rsp_addr_in   = '0;
               rsp_count_in  = used_ff;
               rsp_status_in = cmd.status;
               unique case (cmd.kind)
                  stpt_pkg::KIND_CLEAR: begin
                     used_in       = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = stpt_pkg::STATUS_OK;
                     rsp_count_in  = '0;
                  end
                  stpt_pkg::KIND_DONE: begin
                     rsp_valid_in = 1'b1;
                  end
                  stpt_pkg::KIND_ADD: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = stpt_pkg::STATUS_OK;
                     priority if (merge) begin
                        wr_en       = 1'b1;
                        wr_addr     = last_idx[IDX_W-1:0];
                        wr_data     = {last_start_ff, cmd.limit, cmd.node};
                        last_end_in = cmd.limit;
                     end else if (table_full) begin
                        rsp_status_in = stpt_pkg::STATUS_TABLE_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        last_start_in = cmd.start;
                        last_end_in   = cmd.limit;
                        last_node_in  = cmd.node;
                        used_in       = used_ff + COUNT_W'(1);
                        rsp_count_in  = used_ff + COUNT_W'(1);
                     end
                  end
                  stpt_pkg::KIND_WALK: begin
                     idx_in    = '0;
                     off_in    = cmd.offset;
                     target_in = cmd.node;
                  end
               endcase
            end
         end
         stpt_pkg::BACK_WALK: begin
            priority if (hit) begin
               hit_start_in = a_start_ff;
            end else if (live) begin
               off_in = rem[ADDR_BITS-1:0];
            end else if (walk_done) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stpt_pkg::STATUS_OUT_OF_RANGE;
               rsp_addr_in   = '0;
               rsp_count_in  = used_ff;
            end
         end
         stpt_pkg::BACK_ADDR: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = stpt_pkg::STATUS_OK;
            rsp_addr_in   = hit_start_ff + off_ff;
            rsp_count_in  = used_ff;
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp.ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stpt_pkg::BACK_IDLE;
         used_ff      <= '0;
         p1_ff        <= 1'b0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         p1_ff        <= p1_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_start_ff <= last_start_in;
      last_end_ff   <= last_end_in;
      last_node_ff  <= last_node_in;
      idx_ff        <= idx_in;
      a_match_ff    <= a_match_in;
      a_size_ff     <= a_size_in;
      a_start_ff    <= a_start_in;
      off_ff        <= off_in;
      target_ff     <= target_in;
      hit_start_ff  <= hit_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_count_ff  <= rsp_count_in;
   end
endmodule

/* design/stpt_checker.sv */
// Port-level checker for the segment table page translator, bound to the top level.
// Uses stpt_pkg for the status codes.
module stpt_checker #(
   parameter int MAX_SEGMENTS = stpt_pkg::MAX_SEGMENTS_DEF,
   parameter int ADDR_BITS    = stpt_pkg::ADDR_BITS_DEF
) (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     req_valid,
   input logic                                     req_ready,
   input logic                                     rsp_valid,
   input logic                                     rsp_ready,
   input logic [stpt_pkg::STATUS_W-1:0]            rsp_status,
   input logic [ADDR_BITS-1:0]                     rsp_phys_addr,
   input logic [$clog2(MAX_SEGMENTS + 1)-1:0]      rsp_segment_count
);
   localparam int PEND_W = $clog2(stpt_pkg::QUEUE_DEPTH + 3) + 1;

   logic [PEND_W-1:0] pending_ff, pending_in;
   logic              req_take;
   logic              rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + PEND_W'(1);
      end else if (rsp_take && !req_take) begin
         pending_in = pending_ff - PEND_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_phys_addr) && $stable(rsp_segment_count))
      else $error("Result changed or vanished while stalled.");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("Result shown with no request outstanding.");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != stpt_pkg::STATUS_OK) |-> rsp_phys_addr == '0)
      else $error("Non-zero address on an unsuccessful result.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_segment_count <= ($clog2(MAX_SEGMENTS + 1))'(MAX_SEGMENTS))
      else $error("Segment count beyond table size.");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= stpt_pkg::STATUS_SKIPPED)
      else $error("Undefined status code on a result.");
endmodule

bind segment_table_page_translator stpt_checker #(
   .MAX_SEGMENTS (MAX_SEGMENTS),
   .ADDR_BITS    (ADDR_BITS)
) u_stpt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_status        (rsp.status),
   .rsp_phys_addr     (rsp.phys_addr),
   .rsp_segment_count (rsp.segment_count)
);

/* test/segment_table_page_translator_tb.sv */
// Self-checking testbench for segment_table_page_translator: drives requests and register
// writes, predicts every answer and compares it field by field with what comes out.
// Depends on stpt_pkg, stpt_req_if and stpt_rsp_if, and on the block itself.
module segment_table_page_translator_tb;
   import stpt_pkg::*;

   localparam int ADDR_BITS    = ADDR_BITS_DEF;
   localparam int MAX_SEGMENTS = MAX_SEGMENTS_DEF;
   localparam int COUNT_W      = $clog2(MAX_SEGMENTS + 1);
   localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_BITS) - 64'd1;

   typedef struct {
      opcode_type                opcode;
      logic [ADDR_BITS-1:0]      block_start;
      logic [ADDR_BITS-1:0]      range_end;
      logic                      block_online;
      logic signed [NODE_W-1:0]  node;
      logic [PAGE_INDEX_W-1:0]   page_index;
   } table_request_type;

   typedef struct {
      status_type            status;
      logic [ADDR_BITS-1:0]  phys_addr;
      logic [COUNT_W-1:0]    segment_count;
   } table_answer_type;

   class translator_scoreboard;
      logic [ADDR_BITS-1:0]     seg_start [MAX_SEGMENTS];
      logic [ADDR_BITS-1:0]     seg_end [MAX_SEGMENTS];
      logic [SEG_NODE_W-1:0]    seg_node [MAX_SEGMENTS];
      int unsigned              seg_used;
      logic [PAGE_ORDER_W-1:0]  page_order;
      logic [BLOCK_SHIFT_W-1:0] block_shift;
      logic [MAX_NODES_W-1:0]   max_nodes;
      table_answer_type         pending_answers [$];
      int unsigned              failures;
      int unsigned              op_seen [4];
      int unsigned              status_seen [8];

      function new();
         page_order  = PAGE_ORDER_RESET;
         block_shift = BLOCK_SHIFT_RESET;
         max_nodes   = MAX_NODES_RESET;
         seg_used    = 0;
         failures    = 0;
      endfunction

      function void set_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_PAGE_ORDER: begin
               page_order = value[PAGE_ORDER_W-1:0];
            end
            REG_BLOCK_SHIFT: begin
               block_shift = value[BLOCK_SHIFT_W-1:0];
            end
            REG_MAX_NODES: begin
               max_nodes = value[MAX_NODES_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      // Total number of bytes that one node holds across all of its segments.
      function logic [63:0] node_bytes(logic [SEG_NODE_W-1:0] n);
         logic [63:0] total;
         total = 64'd0;
         for (int i = 0; i < seg_used; i++) begin
            if (seg_node[i] == n) begin
               total += 64'(seg_end[i]) - 64'(seg_start[i]) + 64'd1;
            end
         end
         return total;
      endfunction

      function logic [SEG_NODE_W-1:0] held_node();
         if (seg_used == 0) begin
            return '0;
         end
         return seg_node[$urandom_range(seg_used - 1)];
      endfunction

      function void note_request(table_request_type r);
         table_answer_type  a;
         logic [63:0]       start;
         logic [63:0]       rend;
         logic [63:0]       span;
         logic [63:0]       stop;
         logic [63:0]       off;
         logic [63:0]       diff;
         logic [79:0]       wide;
         logic [NODE_W-1:0] nd;
         int                last;
         bit                found;
         a.status    = STATUS_OK;
         a.phys_addr = '0;
         start       = 64'(r.block_start);
         rend        = 64'(r.range_end);
         nd          = r.node;
         last        = int'(seg_used) - 1;
         case (r.opcode)
            OP_CLEAR: begin
               seg_used = 0;
            end
            OP_ADD: begin
               if (start >= rend || !r.block_online) begin
                  a.status = STATUS_SKIPPED;
               end else if (nd[NODE_W-1]) begin
                  a.status = STATUS_NO_NODE;
               end else if (nd >= max_nodes) begin
                  a.status = STATUS_SKIPPED;
               end else begin
                  span = (block_shift >= ADDR_BITS) ? ADDR_MASK
                                                    : (64'd1 << block_shift) - 64'd1;
                  stop = (span > ADDR_MASK - start) ? ADDR_MASK : start + span;
                  if (stop > rend) begin
                     stop = rend;
                  end
                  // A segment that ends at the top of the address space never grows.
                  if (seg_used > 0 && 64'(seg_end[last]) != ADDR_MASK
                      && start == 64'(seg_end[last]) + 64'd1
                      && seg_node[last] == nd[SEG_NODE_W-1:0]) begin
                     seg_end[last] = stop[ADDR_BITS-1:0];
                  end else if (seg_used >= MAX_SEGMENTS) begin
                     a.status = STATUS_TABLE_FULL;
                  end else begin
                     seg_start[seg_used] = start[ADDR_BITS-1:0];
                     seg_end[seg_used]   = stop[ADDR_BITS-1:0];
                     seg_node[seg_used]  = nd[SEG_NODE_W-1:0];
                     seg_used++;
                  end
               end
            end
            OP_TRANSLATE: begin
               wide     = 80'(r.page_index) << page_order;
               a.status = STATUS_OUT_OF_RANGE;
               if (!nd[NODE_W-1] && wide[79:ADDR_BITS] == '0) begin
                  off   = wide[63:0];
                  found = 1'b0;
                  for (int i = 0; i < seg_used; i++) begin
                     if (!found && seg_node[i] == nd[SEG_NODE_W-1:0]) begin
                        diff = 64'(seg_end[i]) - 64'(seg_start[i]);
                        if (off <= diff) begin
                           a.status    = STATUS_OK;
                           a.phys_addr = seg_start[i] + off[ADDR_BITS-1:0];
                           found       = 1'b1;
                        end else begin
                           off -= diff + 64'd1;
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
         a.segment_count = COUNT_W'(seg_used);
         pending_answers.push_back(a);
         op_seen[r.opcode]++;
         status_seen[a.status]++;
      endfunction

      function void report_mismatch(string field, logic [63:0] want, logic [63:0] got);
         failures++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      endfunction

      function void check_answer(table_answer_type got);
         table_answer_type want;
         if (pending_answers.size() == 0) begin
            failures++;
            $display("%0t: unexpected answer, expected none, actual status %0d, address %0h, count %0d",
                     $time, got.status, got.phys_addr, got.segment_count);
            return;
         end
         want = pending_answers.pop_front();
         if (got.status != want.status) begin
            report_mismatch("status", 64'(want.status), 64'(got.status));
         end
         if (got.phys_addr != want.phys_addr) begin
            report_mismatch("phys_addr", 64'(want.phys_addr), 64'(got.phys_addr));
         end
         if (got.segment_count != want.segment_count) begin
            report_mismatch("segment_count", 64'(want.segment_count),
                            64'(got.segment_count));
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   stpt_req_if req_chan ();
   stpt_rsp_if rsp_chan ();

   translator_scoreboard board;

   int unsigned send_idle_pct = 35;
   int unsigned recv_idle_pct = 79;
   int unsigned hold_off_left = 0;

   // State of the run of contiguous blocks that the random adds are drawn from.
   logic signed [NODE_W-1:0] run_node;
   logic [63:0]              run_next;
   int                       run_left;

   segment_table_page_translator uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .rsp     (rsp_chan),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #10 clock = ~clock;

   function automatic table_request_type compose_request(opcode_type op, logic [63:0] start,
                                                         logic [63:0] rend, logic online,
                                                         logic signed [NODE_W-1:0] nd,
                                                         logic [PAGE_INDEX_W-1:0] idx);
      table_request_type r;
      r.opcode       = op;
      r.block_start  = start[ADDR_BITS-1:0];
      r.range_end    = rend[ADDR_BITS-1:0];
      r.block_online = online;
      r.node         = nd;
      r.page_index   = idx;
      return r;
   endfunction

   function automatic table_request_type random_request();
      table_request_type r;
      logic [63:0]       size;
      logic [63:0]       span;
      int                pick;
      pick = $urandom_range(99);
      r = compose_request(OP_NOP, {$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom),
                          NODE_W'($urandom), PAGE_INDEX_W'({$urandom, $urandom}));
      size = (board.block_shift >= ADDR_BITS) ? (64'd1 << ADDR_BITS)
                                              : (64'd1 << board.block_shift);
      if (pick < ((board.seg_used >= MAX_SEGMENTS) ? 4 : 1)) begin
         r.opcode = OP_CLEAR;
      end else if (pick < 5) begin
         r.opcode = OP_NOP;
      end else if (pick < 12) begin
         r.opcode = opcode_type'($urandom_range(3));
      end else if (pick < 62) begin
         r.opcode       = OP_ADD;
         r.block_online = 1'b1;
         if (run_left == 0 || run_next > ADDR_MASK) begin
            run_node = ($urandom_range(9) == 0) ? NODE_W'($urandom)
                       : NODE_W'($urandom_range(int'(board.max_nodes) - 1));
            run_next = {$urandom, $urandom} & ADDR_MASK & ~(size - 64'd1);
            run_left = $urandom_range(1, 8);
         end
         r.node        = run_node;
         r.block_start = run_next[ADDR_BITS-1:0];
         r.range_end   = ADDR_MASK[ADDR_BITS-1:0];
         if ($urandom_range(3) == 0) begin
            r.range_end = ADDR_BITS'(run_next + ({$urandom, $urandom} % size));
         end
         run_next += ($urandom_range(1) == 0) ? size : 2 * size;
         run_left--;
         case ($urandom_range(19))
            0: begin
               r.block_online = 1'b0;
            end
            1: begin
               r.node = {1'b1, 8'($urandom)};
            end
            2: begin
               r.range_end = r.block_start - ADDR_BITS'($urandom_range(1));
            end
            default: begin
            end
         endcase
      end else begin
         r.opcode = OP_TRANSLATE;
         if ($urandom_range(9) != 0) begin
            r.node = {1'b0, board.held_node()};
         end
         span = board.node_bytes(r.node[SEG_NODE_W-1:0]) >> board.page_order;
         pick = $urandom_range(9);
         if (span != 0 && pick < 8) begin
            r.page_index = PAGE_INDEX_W'({$urandom, $urandom} % span);
         end else if (pick == 8) begin
            r.page_index = PAGE_INDEX_W'(span);
         end
      end
      return r;
   endfunction

   task automatic send_request(input table_request_type r);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.opcode       <= r.opcode;
      req_chan.block_start  <= r.block_start;
      req_chan.range_end    <= r.range_end;
      req_chan.block_online <= r.block_online;
      req_chan.node         <= r.node;
      req_chan.page_index   <= r.page_index;
      do @(posedge clock); while (!req_chan.ready);
      board.note_request(r);
   endtask

   task automatic configure(input logic [PAGE_ORDER_W-1:0] ps,
                            input logic [BLOCK_SHIFT_W-1:0] bs,
                            input logic [MAX_NODES_W-1:0] mn);
      logic [CSR_DATA_W-1:0] value [3];
      int                    i;
      value[0] = CSR_DATA_W'(ps);
      value[1] = CSR_DATA_W'(bs);
      value[2] = CSR_DATA_W'(mn);
      for (i = 0; i < 3; i++) begin
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= {reg_index_type'(i), 2'b00};
         pwdata  <= value[i];
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
         board.set_register(reg_index_type'(i), value[i]);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (board.pending_answers.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      table_answer_type seen;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.status        = status_type'(rsp_chan.status);
            seen.phys_addr     = rsp_chan.phys_addr;
            seen.segment_count = rsp_chan.segment_count;
            board.check_answer(seen);
         end
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_off_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      logic [PAGE_ORDER_W-1:0]  ps_list [6];
      logic [BLOCK_SHIFT_W-1:0] bs_list [6];
      logic [MAX_NODES_W-1:0]   mn_list [6];
      int                       p;
      ps_list = '{5'd12, 5'd30, 5'd0, 5'd21, 5'd16, 5'd13};
      bs_list = '{6'd27, 6'd40, 6'd12, 6'd20, 6'd33, 6'd27};
      mn_list = '{9'd16, 9'd256, 9'd1, 9'd8, 9'd200, 9'd3};
      board = new();
      run_left = 0;
      run_node = '0;
      run_next = '0;
      reset                 <= 1'b1;
      psel                  <= 1'b0;
      penable               <= 1'b0;
      pwrite                <= 1'b0;
      paddr                 <= '0;
      pwdata                <= '0;
      req_chan.valid        <= 1'b0;
      req_chan.opcode       <= OP_NOP;
      req_chan.block_start  <= '0;
      req_chan.range_end    <= '0;
      req_chan.block_online <= 1'b0;
      req_chan.node         <= '0;
      req_chan.page_index   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Register reset values, merging, clipping, skipped blocks and the top of memory.
      send_request(compose_request(OP_TRANSLATE, 0, 0, 1'b0, 0, 0));
      send_request(compose_request(OP_NOP, ADDR_MASK, ADDR_MASK, 1'b1, -1, '1));
      send_request(compose_request(OP_ADD, 0, ADDR_MASK, 1'b1, 0, 0));
      send_request(compose_request(OP_ADD, 64'd1 << 27, ADDR_MASK, 1'b1, 0, 0));
      send_request(compose_request(OP_ADD, 64'd2 << 27, ADDR_MASK, 1'b1, 1, 0));
      send_request(compose_request(OP_ADD, 64'd3 << 27, (64'd3 << 27) + 64'h123, 1'b1, 1, 0));
      send_request(compose_request(OP_ADD, 5, 5, 1'b1, 3, 0));
      send_request(compose_request(OP_ADD, 64'd4 << 27, ADDR_MASK, 1'b0, 3, 0));
      send_request(compose_request(OP_ADD, 64'd4 << 27, ADDR_MASK, 1'b1, -1, 0));
      send_request(compose_request(OP_ADD, 64'd4 << 27, ADDR_MASK, 1'b1, -256, 0));
      send_request(compose_request(OP_ADD, 64'd4 << 27, ADDR_MASK, 1'b1, 16, 0));
      send_request(compose_request(OP_ADD, 64'd8 << 27, ADDR_MASK, 1'b1, 15, 0));
      send_request(compose_request(OP_ADD, ADDR_MASK - 64'hFFF, ADDR_MASK, 1'b1, 2, 0));
      send_request(compose_request(OP_ADD, 0, ADDR_MASK, 1'b1, 2, 0));
      send_request(compose_request(OP_TRANSLATE, 0, 0, 1'b0, 0, 0));
      send_request(compose_request(OP_TRANSLATE, 0, 0, 1'b0, 0, 40'hFFFF));
      send_request(compose_request(OP_TRANSLATE, 0, 0, 1'b0, 0, 40'h10000));
      send_request(compose_request(OP_TRANSLATE, 0, 0, 1'b0, 1, 40'h8000));
      send_request(compose_request(OP_TRANSLATE, 0, 0, 1'b0, -1, 0));
      send_request(compose_request(OP_TRANSLATE, 0, 0, 1'b0, 2, 1));
      send_request(compose_request(OP_TRANSLATE, 0, 0, 1'b0, 0, '1));
      send_request(compose_request(OP_CLEAR, 0, 0, 1'b0, 0, 0));
      send_request(compose_request(OP_TRANSLATE, 0, 0, 1'b0, 0, 0));
      drain();

      // A page order of 30, a block shift beyond the address width and the highest node.
      configure(5'd30, 6'd63, 9'd256);
      send_request(compose_request(OP_ADD, 64'h1234_5000, 64'h2000_0000_0000, 1'b1, 255, 0));
      send_request(compose_request(OP_TRANSLATE, 0, 0, 1'b0, 255, 1));
      send_request(compose_request(OP_TRANSLATE, 0, 0, 1'b0, 255, 40'h40_0000));
      send_request(compose_request(OP_ADD, 64'h2000_0000_0001, ADDR_MASK, 1'b1, 255, 0));
      send_request(compose_request(OP_TRANSLATE, 0, 0, 1'b0, 255, '1));

      for (p = 0; p < 6; p++) begin
         drain();
         configure(ps_list[p], bs_list[p], mn_list[p]);
         send_idle_pct = (p < 2) ? 35 : (p < 4) ? 79 : 0;
         recv_idle_pct = (p < 2) ? 79 : (p < 4) ? 35 : 0;
         if (p == 4) begin
            hold_off_left = 400;
         end
         run_left = 0;
         repeat (125) send_request(random_request());
      end
      drain();
      repeat (MAX_SEGMENTS + 8) @(posedge clock);

      $display("Covered %0d clears, %0d adds, %0d translates and %0d unused-opcode requests",
               board.op_seen[OP_CLEAR], board.op_seen[OP_ADD], board.op_seen[OP_TRANSLATE],
               board.op_seen[OP_NOP]);
      $display("Answers: %0d ok, %0d out of range, %0d no node, %0d table full, %0d skipped",
               board.status_seen[STATUS_OK], board.status_seen[STATUS_OUT_OF_RANGE],
               board.status_seen[STATUS_NO_NODE], board.status_seen[STATUS_TABLE_FULL],
               board.status_seen[STATUS_SKIPPED]);
      if (board.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Run timed out with %0d answers outstanding", board.pending_answers.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
